>>> sv/ipsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsh_pkg: shared types and constants of the IPv6 prefix hash set
// Field widths, status and mode codes, the stored entry record and the
// prefix mask helper.
// ----------------------------------------------------------------------------
package ipsh_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_BITS_DEF = 10;
    localparam int SLOTS_DEF      = 4;

    // Fixed geometry of the prefix walk
    localparam int PREFIX_LENGTHS = 128;
    localparam int PFX_IDX_W      = 7;
    localparam int HOST_PREFIX    = 128;

    // Field widths
    localparam int ADDR_W   = 64;
    localparam int PLEN_W   = 8;
    localparam int TIME_W   = 32;
    localparam int SEED_W   = 32;
    localparam int COUNT_W  = 13;

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_TEST = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_DONE       = 3'd0,
        ST_FOUND      = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_EXISTS     = 3'd3,
        ST_FULL       = 3'd4,
        ST_BAD_PREFIX = 3'd5,
        ST_EXPIRED    = 3'd6
    } status_t;

    // One stored network
    typedef struct packed {
        logic [ADDR_W-1:0] addr_hi;
        logic [ADDR_W-1:0] addr_lo;
        logic [PLEN_W-1:0] prefix;
        logic [TIME_W-1:0] expiry;
    } ent_t;

    // Keep the top p bits; zero clears all, 128 and above keeps all
    function automatic logic [2*ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] p);
        logic [2*ADDR_W-1:0] m;
        if (p == '0)
            m = '0;
        else if (p >= PLEN_W'(HOST_PREFIX))
            m = '1;
        else
            m = ~({(2*ADDR_W){1'b1}} >> p[PFX_IDX_W-1:0]);
        return m;
    endfunction

    function automatic logic bad_prefix(input logic [PLEN_W-1:0] p);
        return (p == '0) || (p > PLEN_W'(HOST_PREFIX));
    endfunction

endpackage

>>> sv/ipsh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsh_if: request and response channels of the IPv6 prefix hash set
// Valid/ready channels; a beat moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface ipsh_req_if import ipsh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [ADDR_W-1:0] addr_hi;
    logic [ADDR_W-1:0] addr_lo;
    logic [PLEN_W-1:0] prefix_len;
    logic [TIME_W-1:0] timeout;
    logic [TIME_W-1:0] now;

    modport source (output valid, mode, addr_hi, addr_lo, prefix_len, timeout, now,
                    input ready);
    modport sink   (input valid, mode, addr_hi, addr_lo, prefix_len, timeout, now,
                    output ready);
endinterface

interface ipsh_rsp_if import ipsh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic [COUNT_W-1:0] element_count;

    modport source (output valid, status, element_count, input ready);
    modport sink   (input valid, status, element_count, output ready);
endinterface

>>> sv/ipsh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsh_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ipsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> sv/ipsh_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipsh_hash: iterative jhash2 bucket hash over a 128-bit key
// Loads the seeded state on start, runs one mix line per cycle and pulses
// done with the bucket index.
// ----------------------------------------------------------------------------
module ipsh_hash import ipsh_pkg::*; #(
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SEED_W-1:0]     seed,
    input  logic [ADDR_W-1:0]     key_hi,
    input  logic [ADDR_W-1:0]     key_lo,
    output logic                  done,
    output logic [TABLE_BITS-1:0] bucket
);

    localparam logic [31:0] JH_INIT = 32'hdeadbeff;
    localparam int          STEPS   = 13;
    localparam int          STEP_W  = $clog2(STEPS);

    logic [31:0]       a_reg, b_reg, c_reg, w3_reg;
    logic [31:0]       a_next, b_next, c_next, w3_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [31:0]       base;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    assign base = JH_INIT + seed;

    // One mix line per step
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        w3_next   = w3_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = base + key_hi[63:32];
            b_next    = base + key_hi[31:0];
            c_next    = base + key_lo[63:32];
            w3_next   = key_lo[31:0];
            step_next = '0;
            run_next  = 1'b1;
        end else if (run_reg) begin
            case (step_reg)
                4'd0: begin a_next = (a_reg - c_reg) ^ rotl(c_reg, 4);  c_next = c_reg + b_reg; end
                4'd1: begin b_next = (b_reg - a_reg) ^ rotl(a_reg, 6);  a_next = a_reg + c_reg; end
                4'd2: begin c_next = (c_reg - b_reg) ^ rotl(b_reg, 8);  b_next = b_reg + a_reg; end
                4'd3: begin a_next = (a_reg - c_reg) ^ rotl(c_reg, 16); c_next = c_reg + b_reg; end
                4'd4: begin b_next = (b_reg - a_reg) ^ rotl(a_reg, 19); a_next = a_reg + c_reg; end
                4'd5: begin c_next = (c_reg - b_reg) ^ rotl(b_reg, 4);  b_next = b_reg + a_reg; end
                4'd6: begin c_next = (c_reg ^ b_reg) - rotl(b_reg, 14); a_next = a_reg + w3_reg; end
                4'd7: a_next = (a_reg ^ c_reg) - rotl(c_reg, 11);
                4'd8: b_next = (b_reg ^ a_reg) - rotl(a_reg, 25);
                4'd9: c_next = (c_reg ^ b_reg) - rotl(b_reg, 16);
                4'd10: a_next = (a_reg ^ c_reg) - rotl(c_reg, 4);
                4'd11: b_next = (b_reg ^ a_reg) - rotl(a_reg, 14);
                4'd12: c_next = (c_reg ^ b_reg) - rotl(b_reg, 24);
                default: ;
            endcase
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(STEPS - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Hash state
    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        c_reg  <= c_next;
        w3_reg <= w3_next;
    end

    assign done   = done_reg;
    assign bucket = c_reg[TABLE_BITS-1:0];

endmodule

>>> sv/ipv6_prefix_hash_set_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_prefix_hash_set_unit: IPv6 network set in a bucketed hash table
// Add, delete and membership test of IPv6 networks with expiry, per-prefix
// counts and an element count; one response beat per request beat.
// ----------------------------------------------------------------------------
// Requests are handled one at a time; a request is taken while the previous
// response still waits in the output register. After reset a clearing pass
// over the bucket words and prefix counts runs before the first request is
// taken. A test walks the prefix lengths in turn, up to all 128, through the
// prefix count memory; each length in use adds a hash and a bucket read plus
// an entry read for each occupied slot scanned. A delete hashes the network
// and scans its bucket. An add runs a test first and then inserts. An add on
// a full table first sweeps every bucket for expired entries. The bucket hash
// unit runs one mix line per cycle, and each memory has a single read port.
// ----------------------------------------------------------------------------
module ipv6_prefix_hash_set_unit import ipsh_pkg::*; #(
    parameter int TABLE_BITS       = TABLE_BITS_DEF,
    parameter int SLOTS_PER_BUCKET = SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SEED_W-1:0] cfg_data,
    ipsh_req_if.sink          req,
    ipsh_rsp_if.source        rsp
);

    localparam int BUCKETS = 1 << TABLE_BITS;
    localparam int SLOTS   = SLOTS_PER_BUCKET;
    localparam int ENTRIES = BUCKETS * SLOTS;
    localparam int EIDX_W  = $clog2(ENTRIES);
    localparam int HW_W    = $clog2(SLOTS + 1);
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int BKT_W   = SLOTS + HW_W;
    localparam int CLR_N   = (BUCKETS > PREFIX_LENGTHS) ? BUCKETS : PREFIX_LENGTHS;
    localparam int CLR_W   = $clog2(CLR_N);
    localparam int ENT_W   = $bits(ent_t);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_PRB_RD, S_PRB_CHK, S_HASH, S_BKT_RD, S_BKT_LD,
        S_SCAN_SLOT, S_SCAN_CHK, S_REM, S_REM_PFX, S_INS, S_INS_PFX, S_FIN
    } state_t;

    typedef enum logic [1:0] {
        CTX_PROBE, CTX_DEL, CTX_SWEEP, CTX_INS
    } ctx_t;

    // Registers
    state_t             state_reg, state_next;
    ctx_t               ctx_reg, ctx_next;
    logic [SEED_W-1:0]  seed_reg, seed_next;
    mode_t              mode_reg, mode_next;
    logic [PLEN_W-1:0]  p_reg, p_next;
    logic [TIME_W-1:0]  tmo_reg, tmo_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [ADDR_W-1:0]  base_hi_reg, base_hi_next, base_lo_reg, base_lo_next;
    logic [ADDR_W-1:0]  cur_hi_reg, cur_hi_next, cur_lo_reg, cur_lo_next;
    logic [PLEN_W-1:0]  cur_p_reg, cur_p_next;
    logic [PLEN_W-1:0]  rem_p_reg, rem_p_next;
    logic [TABLE_BITS-1:0] bkt_reg, bkt_next;
    logic [SLOTS-1:0]   used_reg, used_next;
    logic [HW_W-1:0]    hw_reg, hw_next;
    logic [HW_W-1:0]    slot_reg, slot_next;
    logic [PFX_IDX_W-1:0] q_reg, q_next;
    logic [CLR_W-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    status_t            res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_st_reg, out_st_next;
    logic [COUNT_W-1:0] out_cnt_reg, out_cnt_next;

    // Memory ports
    logic               ent_we;
    logic [EIDX_W-1:0]  ent_waddr, ent_raddr;
    ent_t               ent_wdata, ent_rdata;
    logic               bkt_we;
    logic [TABLE_BITS-1:0] bkt_waddr, bkt_raddr;
    logic [BKT_W-1:0]   bkt_wdata, bkt_rdata;
    logic               pfx_we;
    logic [PFX_IDX_W-1:0] pfx_waddr, pfx_raddr;
    logic [CNT_W-1:0]   pfx_wdata, pfx_rdata;

    // Hash unit
    logic               hash_start, hash_done;
    logic [ADDR_W-1:0]  hash_hi, hash_lo;
    logic [TABLE_BITS-1:0] hash_bucket;

    // Helpers
    logic [2*ADDR_W-1:0] req_masked, q_masked;
    logic [PLEN_W-1:0]  q_plen;
    logic [HW_W-1:0]    lim;
    logic               scan_end;
    logic               free_found;
    logic [SLOT_W-1:0]  free_slot;
    logic [EIDX_W-1:0]  scan_idx, ins_idx;
    logic               ent_exp, ent_match;
    logic [SLOTS-1:0]   rem_used;
    logic [HW_W-1:0]    rem_hw;
    logic               rem_p_ok;
    logic               prb_adv, prb_end;
    status_t            prb_st;

    ipsh_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ent_ram (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );

    ipsh_ram #(.WIDTH(BKT_W), .DEPTH(BUCKETS)) u_bkt_ram (
        .clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
        .raddr(bkt_raddr), .rdata(bkt_rdata)
    );

    ipsh_ram #(.WIDTH(CNT_W), .DEPTH(PREFIX_LENGTHS)) u_pfx_ram (
        .clk(clk), .we(pfx_we), .waddr(pfx_waddr), .wdata(pfx_wdata),
        .raddr(pfx_raddr), .rdata(pfx_rdata)
    );

    ipsh_hash #(.TABLE_BITS(TABLE_BITS)) u_hash (
        .clk(clk), .rst_n(rst_n), .start(hash_start), .seed(seed_reg),
        .key_hi(hash_hi), .key_lo(hash_lo), .done(hash_done), .bucket(hash_bucket)
    );

    // Address masking
    assign req_masked = {req.addr_hi, req.addr_lo} & prefix_mask(req.prefix_len);
    assign q_plen     = {1'b0, q_reg} + PLEN_W'(1);
    assign q_masked   = {base_hi_reg, base_lo_reg} & prefix_mask(q_plen);

    // Bucket scan bounds and slot addressing
    assign lim      = (hw_reg > HW_W'(SLOTS)) ? HW_W'(SLOTS) : hw_reg;
    assign scan_end = (slot_reg >= lim);
    assign scan_idx = EIDX_W'(bkt_reg) * EIDX_W'(SLOTS) + EIDX_W'(slot_reg);
    assign ins_idx  = EIDX_W'(bkt_reg) * EIDX_W'(SLOTS) + EIDX_W'(free_slot);

    // First free slot, lowest index wins
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(i);
            end
        end
    end

    // Entry compare on the read data
    assign ent_exp   = (ent_rdata.expiry != '0) && (ent_rdata.expiry < now_reg);
    assign ent_match = (ent_rdata.addr_hi == cur_hi_reg) && (ent_rdata.addr_lo == cur_lo_reg)
                       && (ent_rdata.prefix == cur_p_reg);

    // Bucket word after removing the current slot
    assign rem_used = used_reg & ~(SLOTS'(1) << slot_reg);
    assign rem_hw   = ((slot_reg + HW_W'(1)) == hw_reg) ? (hw_reg - HW_W'(1)) : hw_reg;
    assign rem_p_ok = !bad_prefix(rem_p_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        ctx_next       = ctx_reg;
        seed_next      = cfg_we ? cfg_data : seed_reg;
        mode_next      = mode_reg;
        p_next         = p_reg;
        tmo_next       = tmo_reg;
        now_next       = now_reg;
        base_hi_next   = base_hi_reg;
        base_lo_next   = base_lo_reg;
        cur_hi_next    = cur_hi_reg;
        cur_lo_next    = cur_lo_reg;
        cur_p_next     = cur_p_reg;
        rem_p_next     = rem_p_reg;
        bkt_next       = bkt_reg;
        used_next      = used_reg;
        hw_next        = hw_reg;
        slot_next      = slot_reg;
        q_next         = q_reg;
        clr_next       = clr_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_st_next    = out_st_reg;
        out_cnt_next   = out_cnt_reg;

        ent_we    = 1'b0;
        ent_waddr = ins_idx;
        ent_wdata = '{addr_hi: base_hi_reg, addr_lo: base_lo_reg, prefix: p_reg,
                      expiry: (tmo_reg == '0) ? '0 : (now_reg + tmo_reg)};
        ent_raddr = scan_idx;
        bkt_we    = 1'b0;
        bkt_waddr = bkt_reg;
        bkt_wdata = {rem_hw, rem_used};
        bkt_raddr = bkt_reg;
        pfx_we    = 1'b0;
        pfx_waddr = PFX_IDX_W'(rem_p_reg - PLEN_W'(1));
        pfx_wdata = pfx_rdata - CNT_W'(1);
        pfx_raddr = PFX_IDX_W'(rem_p_reg - PLEN_W'(1));

        hash_start = 1'b0;
        hash_hi    = cur_hi_reg;
        hash_lo    = cur_lo_reg;

        prb_adv = 1'b0;
        prb_end = 1'b0;
        prb_st  = ST_NOT_FOUND;

        case (state_reg)
            // Clear the slot bits of every bucket word (high water set to one) and the prefix counts after reset
            S_CLEAR: begin
                bkt_waddr = clr_reg[TABLE_BITS-1:0];
                bkt_wdata = {HW_W'(1), SLOTS'(0)};
                bkt_we    = ({1'b0, clr_reg} < (CLR_W + 1)'(BUCKETS));
                pfx_waddr = clr_reg[PFX_IDX_W-1:0];
                pfx_wdata = '0;
                pfx_we    = ({1'b0, clr_reg} < (CLR_W + 1)'(PREFIX_LENGTHS));
                clr_next  = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(CLR_N - 1))
                    state_next = S_IDLE;
            end

            // Take a request beat and dispatch
            S_IDLE: begin
                if (req.valid) begin
                    mode_next = mode_t'(req.mode);
                    p_next    = req.prefix_len;
                    tmo_next  = req.timeout;
                    now_next  = req.now;
                    q_next    = '0;
                    case (mode_t'(req.mode))
                        MODE_ADD: begin
                            base_hi_next = req_masked[2*ADDR_W-1:ADDR_W];
                            base_lo_next = req_masked[ADDR_W-1:0];
                            if (cnt_reg >= CNT_W'(ENTRIES)) begin
                                ctx_next   = CTX_SWEEP;
                                bkt_next   = '0;
                                state_next = S_BKT_RD;
                            end else begin
                                ctx_next   = CTX_PROBE;
                                state_next = S_PRB_RD;
                            end
                        end
                        MODE_DEL: begin
                            if (bad_prefix(req.prefix_len)) begin
                                res_next   = ST_BAD_PREFIX;
                                state_next = S_FIN;
                            end else begin
                                cur_hi_next = req_masked[2*ADDR_W-1:ADDR_W];
                                cur_lo_next = req_masked[ADDR_W-1:0];
                                cur_p_next  = req.prefix_len;
                                hash_start  = 1'b1;
                                hash_hi     = req_masked[2*ADDR_W-1:ADDR_W];
                                hash_lo     = req_masked[ADDR_W-1:0];
                                ctx_next    = CTX_DEL;
                                state_next  = S_HASH;
                            end
                        end
                        MODE_TEST: begin
                            base_hi_next = req.addr_hi;
                            base_lo_next = req.addr_lo;
                            ctx_next     = CTX_PROBE;
                            state_next   = S_PRB_RD;
                        end
                        default: begin
                            res_next   = ST_NOT_FOUND;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            // Walk prefix lengths, skip those not in use
            S_PRB_RD: begin
                pfx_raddr  = q_reg;
                state_next = S_PRB_CHK;
            end

            S_PRB_CHK: begin
                if (pfx_rdata == '0) begin
                    prb_adv = 1'b1;
                end else begin
                    cur_hi_next = q_masked[2*ADDR_W-1:ADDR_W];
                    cur_lo_next = q_masked[ADDR_W-1:0];
                    cur_p_next  = q_plen;
                    hash_start  = 1'b1;
                    hash_hi     = q_masked[2*ADDR_W-1:ADDR_W];
                    hash_lo     = q_masked[ADDR_W-1:0];
                    state_next  = S_HASH;
                end
            end

            // Wait for the bucket index
            S_HASH: begin
                if (hash_done) begin
                    bkt_next   = hash_bucket;
                    state_next = S_BKT_RD;
                end
            end

            S_BKT_RD: begin
                state_next = S_BKT_LD;
            end

            S_BKT_LD: begin
                used_next  = bkt_rdata[SLOTS-1:0];
                hw_next    = bkt_rdata[BKT_W-1:SLOTS];
                slot_next  = '0;
                state_next = (ctx_reg == CTX_INS) ? S_INS : S_SCAN_SLOT;
            end

            // Issue entry reads for occupied slots below the high water
            S_SCAN_SLOT: begin
                if (scan_end) begin
                    case (ctx_reg)
                        CTX_SWEEP: begin
                            if (bkt_reg == TABLE_BITS'(BUCKETS - 1)) begin
                                if (cnt_reg >= CNT_W'(ENTRIES)) begin
                                    res_next   = ST_FULL;
                                    state_next = S_FIN;
                                end else begin
                                    ctx_next   = CTX_PROBE;
                                    q_next     = '0;
                                    state_next = S_PRB_RD;
                                end
                            end else begin
                                bkt_next   = bkt_reg + TABLE_BITS'(1);
                                state_next = S_BKT_RD;
                            end
                        end
                        CTX_DEL: begin
                            res_next   = ST_NOT_FOUND;
                            state_next = S_FIN;
                        end
                        default: prb_adv = 1'b1;
                    endcase
                end else if (used_reg[slot_reg[SLOT_W-1:0]]) begin
                    state_next = S_SCAN_CHK;
                end else begin
                    slot_next = slot_reg + HW_W'(1);
                end
            end

            // Compare the entry that was read
            S_SCAN_CHK: begin
                rem_p_next = ent_rdata.prefix;
                state_next = S_SCAN_SLOT;
                slot_next  = slot_reg + HW_W'(1);
                case (ctx_reg)
                    CTX_SWEEP: begin
                        if (ent_exp) begin
                            slot_next  = slot_reg;
                            state_next = S_REM;
                        end
                    end
                    CTX_DEL: begin
                        if (ent_match) begin
                            slot_next  = slot_reg;
                            state_next = S_REM;
                        end
                    end
                    default: begin
                        if (ent_match) begin
                            slot_next = slot_reg;
                            if (ent_exp) begin
                                state_next = S_REM;
                            end else begin
                                prb_end = 1'b1;
                                prb_st  = ST_FOUND;
                            end
                        end
                    end
                endcase
            end

            // Free the slot and fetch its prefix count
            S_REM: begin
                bkt_we     = 1'b1;
                used_next  = rem_used;
                hw_next    = rem_hw;
                if (cnt_reg != '0)
                    cnt_next = cnt_reg - CNT_W'(1);
                state_next = S_REM_PFX;
            end

            S_REM_PFX: begin
                pfx_we = rem_p_ok && (pfx_rdata != '0);
                case (ctx_reg)
                    CTX_SWEEP: begin
                        slot_next  = slot_reg + HW_W'(1);
                        state_next = S_SCAN_SLOT;
                    end
                    CTX_DEL: begin
                        res_next   = ST_DONE;
                        state_next = S_FIN;
                    end
                    default: begin
                        prb_end = 1'b1;
                        prb_st  = ST_EXPIRED;
                    end
                endcase
            end

            // Store the new entry in the first free slot
            S_INS: begin
                if (free_found) begin
                    ent_we    = 1'b1;
                    bkt_we    = 1'b1;
                    bkt_wdata = {(hw_reg < HW_W'(SLOTS)) ? (hw_reg + HW_W'(1)) : hw_reg,
                                 used_reg | (SLOTS'(1) << free_slot)};
                    cnt_next   = cnt_reg + CNT_W'(1);
                    pfx_raddr  = PFX_IDX_W'(p_reg - PLEN_W'(1));
                    state_next = S_INS_PFX;
                end else begin
                    res_next   = ST_FULL;
                    state_next = S_FIN;
                end
            end

            S_INS_PFX: begin
                pfx_we     = 1'b1;
                pfx_waddr  = PFX_IDX_W'(p_reg - PLEN_W'(1));
                pfx_wdata  = pfx_rdata + CNT_W'(1);
                res_next   = ST_DONE;
                state_next = S_FIN;
            end

            // Load the response beat once the output register is free
            S_FIN: begin
                if (!out_valid_reg || rsp.ready) begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_reg;
                    out_cnt_next   = COUNT_W'(cnt_reg);
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // Advance to the next prefix length
        if (prb_adv) begin
            if (q_reg == PFX_IDX_W'(PREFIX_LENGTHS - 1)) begin
                prb_end = 1'b1;
                prb_st  = ST_NOT_FOUND;
            end else begin
                q_next     = q_reg + PFX_IDX_W'(1);
                state_next = S_PRB_RD;
            end
        end

        // Finish a probe: answer a test, or end an add (exists, bad prefix) or carry it on to insertion
        if (prb_end) begin
            if (mode_reg == MODE_TEST) begin
                res_next   = prb_st;
                state_next = S_FIN;
            end else if (prb_st == ST_FOUND) begin
                res_next   = ST_EXISTS;
                state_next = S_FIN;
            end else if (bad_prefix(p_reg)) begin
                res_next   = ST_BAD_PREFIX;
                state_next = S_FIN;
            end else begin
                cur_hi_next = base_hi_reg;
                cur_lo_next = base_lo_reg;
                cur_p_next  = p_reg;
                hash_start  = 1'b1;
                hash_hi     = base_hi_reg;
                hash_lo     = base_lo_reg;
                ctx_next    = CTX_INS;
                state_next  = S_HASH;
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            ctx_reg       <= CTX_PROBE;
            seed_reg      <= '0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ctx_reg       <= ctx_next;
            seed_reg      <= seed_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        p_reg       <= p_next;
        tmo_reg     <= tmo_next;
        now_reg     <= now_next;
        base_hi_reg <= base_hi_next;
        base_lo_reg <= base_lo_next;
        cur_hi_reg  <= cur_hi_next;
        cur_lo_reg  <= cur_lo_next;
        cur_p_reg   <= cur_p_next;
        rem_p_reg   <= rem_p_next;
        bkt_reg     <= bkt_next;
        used_reg    <= used_next;
        hw_reg      <= hw_next;
        slot_reg    <= slot_next;
        q_reg       <= q_next;
        res_reg     <= res_next;
        out_st_reg  <= out_st_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_st_reg;
    assign rsp.element_count = out_cnt_reg;

    // Element count never passes the table size
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(ENTRIES))
        else $error("element count above table size");

    // The hash unit only reports while the sequencer waits for it
    a_hash_wait: assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> (state_reg == S_HASH))
        else $error("hash result arrived outside the hash wait");

    // A finished request holds while the response register is occupied
    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && !rsp.ready) |=> (state_reg == S_FIN))
        else $error("response overwritten before it was taken");

    // A removal always clears an occupied slot
    a_rem_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REM) |-> used_reg[slot_reg[SLOT_W-1:0]])
        else $error("removal of a free slot");

endmodule
